>>> hw/rtl/pgs_pkg.sv
// ----------------------------------------------------------------------------
// pgs_pkg
// Shared types, widths and the palette key table of the gradient sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package pgs_pkg;

    // fixed field widths
    localparam int SEL_W     = 2;
    localparam int POS_W     = 17;
    localparam int CH_W      = 8;
    localparam int SPAN_W    = 3;
    localparam int KEY_IDX_W = 4;

    // palette codes
    localparam logic [SEL_W-1:0] SEL_OCEAN   = 2'd0;
    localparam logic [SEL_W-1:0] SEL_SUNSET  = 2'd1;
    localparam logic [SEL_W-1:0] SEL_RAINBOW = 2'd2;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } color_t;

    // first key of a palette in the key table, unknown codes fall back to ocean
    function automatic logic [KEY_IDX_W-1:0] pal_base(input logic [SEL_W-1:0] sel);
        logic [KEY_IDX_W-1:0] base;
        unique case (sel)
            SEL_SUNSET:  base = 4'd3;
            SEL_RAINBOW: base = 4'd6;
            default:     base = 4'd0;
        endcase
        return base;
    endfunction

    // key count minus one
    function automatic logic [SPAN_W-1:0] pal_span(input logic [SEL_W-1:0] sel);
        logic [SPAN_W-1:0] span;
        unique case (sel)
            SEL_RAINBOW: span = 3'd6;
            default:     span = 3'd2;
        endcase
        return span;
    endfunction

    // constant key table: ocean, sunset, rainbow back to back
    function automatic color_t key_rom(input logic [KEY_IDX_W-1:0] idx);
        color_t key;
        unique case (idx)
            4'd0:    key = '{r: 8'd0,   g: 8'd64,  b: 8'd128};
            4'd1:    key = '{r: 8'd0,   g: 8'd160, b: 8'd255};
            4'd2:    key = '{r: 8'd0,   g: 8'd64,  b: 8'd128};
            4'd3:    key = '{r: 8'd255, g: 8'd80,  b: 8'd0};
            4'd4:    key = '{r: 8'd255, g: 8'd0,   b: 8'd64};
            4'd5:    key = '{r: 8'd64,  g: 8'd0,   b: 8'd96};
            4'd6:    key = '{r: 8'd255, g: 8'd0,   b: 8'd0};
            4'd7:    key = '{r: 8'd255, g: 8'd127, b: 8'd0};
            4'd8:    key = '{r: 8'd255, g: 8'd255, b: 8'd0};
            4'd9:    key = '{r: 8'd0,   g: 8'd255, b: 8'd0};
            4'd10:   key = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
            4'd11:   key = '{r: 8'd75,  g: 8'd0,   b: 8'd130};
            4'd12:   key = '{r: 8'd148, g: 8'd0,   b: 8'd211};
            default: key = '{r: 8'd0,   g: 8'd0,   b: 8'd0};
        endcase
        return key;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/pgs_if.sv
// ----------------------------------------------------------------------------
// pgs_if
// Valid/ready channels of the gradient sampler: sample request and colour.
// ----------------------------------------------------------------------------
`default_nettype none

// request channel: palette and position
interface pgs_sample_if;
    logic                         valid;
    logic                         ready;
    logic [pgs_pkg::SEL_W-1:0]    palette_sel;
    logic [pgs_pkg::POS_W-1:0]    position;

    modport source (output valid, output palette_sel, output position, input ready);
    modport sink   (input valid, input palette_sel, input position, output ready);
endinterface

// result channel: one rgb888 colour
interface pgs_color_if;
    logic                         valid;
    logic                         ready;
    logic [pgs_pkg::CH_W-1:0]     red;
    logic [pgs_pkg::CH_W-1:0]     green;
    logic [pgs_pkg::CH_W-1:0]     blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/pgs_key_sel.sv
// ----------------------------------------------------------------------------
// pgs_key_sel
// Scales the position by the key count minus one and picks the two keys.
// ----------------------------------------------------------------------------
`default_nettype none

module pgs_key_sel #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic [pgs_pkg::SEL_W-1:0] palette_sel,
    input  wire logic [pgs_pkg::POS_W-1:0] position,
    output pgs_pkg::color_t                key_lo,
    output pgs_pkg::color_t                key_hi,
    output logic [FRAC_BITS-1:0]           frac
);
    import pgs_pkg::*;

    // wide enough for position times six and for the fraction itself
    localparam int SCALED_W = (FRAC_BITS + SPAN_W > POS_W + SPAN_W) ?
                              FRAC_BITS + SPAN_W : POS_W + SPAN_W;

    logic [KEY_IDX_W-1:0] base;
    logic [SPAN_W-1:0]    span;
    logic [SCALED_W-1:0]  scaled;
    logic [SCALED_W-1:0]  idx;
    logic                 at_end;
    logic [KEY_IDX_W-1:0] lo_idx;
    logic [KEY_IDX_W-1:0] last_idx;

    // scaled position, integer part and fraction
    always_comb
    begin
        base     = pal_base(palette_sel);
        span     = pal_span(palette_sel);
        scaled   = SCALED_W'(position) * SCALED_W'(span);
        idx      = scaled >> FRAC_BITS;
        at_end   = (idx >= SCALED_W'(span));
        lo_idx   = base + KEY_IDX_W'(idx[SPAN_W-1:0]);
        last_idx = base + KEY_IDX_W'(span);
    end

    // at or past the last key both ends are the last key with zero weight
    always_comb
    begin
        if (at_end)
        begin
            key_lo = key_rom(last_idx);
            key_hi = key_rom(last_idx);
            frac   = '0;
        end
        else
        begin
            key_lo = key_rom(lo_idx);
            key_hi = key_rom(lo_idx + KEY_IDX_W'(1));
            frac   = scaled[FRAC_BITS-1:0];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/pgs_blend.sv
// ----------------------------------------------------------------------------
// pgs_blend
// Linear blend of one colour channel between two keys by a fixed-point weight.
// ----------------------------------------------------------------------------
`default_nettype none

module pgs_blend #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic [pgs_pkg::CH_W-1:0] lo,
    input  wire logic [pgs_pkg::CH_W-1:0] hi,
    input  wire logic [FRAC_BITS-1:0]     frac,
    output logic [pgs_pkg::CH_W-1:0]      level
);
    import pgs_pkg::*;

    localparam int SUM_W = FRAC_BITS + CH_W + 2;

    logic signed [CH_W:0]    diff;
    logic signed [SUM_W-1:0] base;
    logic signed [SUM_W-1:0] prod;
    logic signed [SUM_W-1:0] sum;

    // lo * 2^f + (hi - lo) * frac, never negative, then drop the fraction
    always_comb
    begin
        diff  = $signed({1'b0, hi}) - $signed({1'b0, lo});
        base  = $signed({2'b00, lo, {FRAC_BITS{1'b0}}});
        prod  = diff * $signed({1'b0, frac});
        sum   = base + prod;
        level = sum[FRAC_BITS+CH_W-1:FRAC_BITS];
    end

endmodule

`default_nettype wire

>>> hw/rtl/palette_gradient_sampler.sv
// ----------------------------------------------------------------------------
// palette_gradient_sampler
// Palette gradient lookup: one rgb888 colour per palette and position item.
// ----------------------------------------------------------------------------
// Usage
//   sample : palette_sel (0 ocean, 1 sunset, 2 rainbow, 3 as ocean) and an
//            unsigned position with FRAC_BITS fraction bits; 1.0 and above
//            return the last key of the palette.
//   color  : red, green, blue of the blended colour, one item per sample.
//   Both channels move an item when valid and ready are high at a clock edge.
// Pipeline
//   Two register stages: a sample register, then the key select and three
//   channel multipliers feeding the result register behind color.valid;
//   one item per cycle is sustained while color.ready stays high.
// Reset
//   rst_n clears both stage valid flags; nothing else needs clearing.
// Stall
//   A stalled result holds in the result register; the sample stage keeps
//   accepting until it is also full, then sample.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module palette_gradient_sampler #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pgs_sample_if.sink  sample,
    pgs_color_if.source color
);
    import pgs_pkg::*;

    logic             s1_valid_reg;
    logic             s1_valid_next;
    logic [SEL_W-1:0] s1_sel_reg;
    logic [POS_W-1:0] s1_pos_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    color_t           out_color_reg;
    color_t           out_color_next;

    logic                 out_free;
    logic                 s1_free;
    color_t               key_lo;
    color_t               key_hi;
    logic [FRAC_BITS-1:0] frac;

    // stage advance conditions
    assign out_free     = !out_valid_reg || color.ready;
    assign s1_free      = !s1_valid_reg || out_free;
    assign sample.ready = s1_free;

    // sample register
    assign s1_valid_next = s1_free ? sample.valid : s1_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && s1_free)
        begin
            s1_sel_reg <= sample.palette_sel;
            s1_pos_reg <= sample.position;
        end
    end

    // key selection and channel blends
    pgs_key_sel #(
        .FRAC_BITS (FRAC_BITS)
    ) u_key_sel (
        .palette_sel (s1_sel_reg),
        .position    (s1_pos_reg),
        .key_lo      (key_lo),
        .key_hi      (key_hi),
        .frac        (frac)
    );

    pgs_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend_r (
        .lo    (key_lo.r),
        .hi    (key_hi.r),
        .frac  (frac),
        .level (out_color_next.r)
    );

    pgs_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend_g (
        .lo    (key_lo.g),
        .hi    (key_hi.g),
        .frac  (frac),
        .level (out_color_next.g)
    );

    pgs_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend_b (
        .lo    (key_lo.b),
        .hi    (key_hi.b),
        .frac  (frac),
        .level (out_color_next.b)
    );

    // result register
    assign out_valid_next = out_free ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && out_free)
        begin
            out_color_reg <= out_color_next;
        end
    end

    assign color.valid = out_valid_reg;
    assign color.red   = out_color_reg.r;
    assign color.green = out_color_reg.g;
    assign color.blue  = out_color_reg.b;

    // an accepted item lands in the sample stage
    a_accept_fills_s1 : assert property (
        @(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> s1_valid_reg
    ) else $error("accepted item did not reach the sample stage");

    // a sample-stage item moving on shows up as a result
    a_s1_moves_to_out : assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_free |=> color.valid
    ) else $error("sample stage item lost on its way to the result register");

    // a blocked sample stage keeps its item
    a_s1_holds : assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_free |=> s1_valid_reg && $stable(s1_pos_reg)
            && $stable(s1_sel_reg)
    ) else $error("sample stage changed while blocked");

    // no new item accepted while both stages are full and stalled
    a_no_overrun : assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_valid_reg && color.valid && !color.ready |-> !sample.ready
    ) else $error("sample accepted with both stages full");

endmodule

`default_nettype wire

>>> test/palette_gradient_sampler_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_gradient_sampler_checker
// Watches the sample and colour channels of the gradient sampler. Every
// accepted sample is turned into the colour it must produce, kept in order,
// and each accepted colour item is compared channel by channel with the
// oldest colour still waiting.
// ----------------------------------------------------------------------------

module palette_gradient_sampler_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic  clk,
    input  logic  rst_n,
    pgs_sample_if sample,
    pgs_color_if  color,
    output int    mismatches,
    output int    outstanding,
    output int    checked
);

    import pgs_pkg::*;

    localparam int KEY_TOTAL = 13;

    // ocean, sunset and rainbow keys back to back
    color_t key_tab [0:KEY_TOTAL-1];

    color_t expected_colours [$];
    color_t want;
    int     err_cnt = 0;
    int     seen = 0;

    initial
    begin
        key_tab[0]  = {8'd0,   8'd64,  8'd128};
        key_tab[1]  = {8'd0,   8'd160, 8'd255};
        key_tab[2]  = {8'd0,   8'd64,  8'd128};
        key_tab[3]  = {8'd255, 8'd80,  8'd0};
        key_tab[4]  = {8'd255, 8'd0,   8'd64};
        key_tab[5]  = {8'd64,  8'd0,   8'd96};
        key_tab[6]  = {8'd255, 8'd0,   8'd0};
        key_tab[7]  = {8'd255, 8'd127, 8'd0};
        key_tab[8]  = {8'd255, 8'd255, 8'd0};
        key_tab[9]  = {8'd0,   8'd255, 8'd0};
        key_tab[10] = {8'd0,   8'd0,   8'd255};
        key_tab[11] = {8'd75,  8'd0,   8'd130};
        key_tab[12] = {8'd148, 8'd0,   8'd211};
    end

    // weighted blend of one channel, floor of the fixed-point sum
    function automatic logic [CH_W-1:0] mix_channel(input logic [CH_W-1:0] a,
                                                    input logic [CH_W-1:0] b,
                                                    input longint frac);
        longint la;
        longint lb;
        longint sum;
        la = a;
        lb = b;
        sum = (la <<< FRAC_BITS) + (lb - la) * frac;
        if (sum < 0)
            sum = 0;
        return CH_W'((sum >> FRAC_BITS) & 8'hFF);
    endfunction

    // colour that a palette and position must give
    function automatic color_t predict_colour(input logic [SEL_W-1:0] sel,
                                              input logic [POS_W-1:0] pos);
        int     first;
        int     span;
        longint scaled;
        longint idx;
        longint frac;
        color_t lo;
        color_t hi;
        color_t res;
        // unknown palette codes read as ocean
        if (sel == SEL_SUNSET)
        begin
            first = 3;
            span  = 2;
        end
        else if (sel == SEL_RAINBOW)
        begin
            first = 6;
            span  = 6;
        end
        else
        begin
            first = 0;
            span  = 2;
        end
        scaled = longint'(pos) * span;
        idx    = scaled >> FRAC_BITS;
        frac   = scaled & ((longint'(1) << FRAC_BITS) - 1);
        // at or past the last key the last key comes back as it is
        if (idx >= span)
            return key_tab[first + span];
        lo = key_tab[first + int'(idx)];
        hi = key_tab[first + int'(idx) + 1];
        res.r = mix_channel(lo.r, hi.r, frac);
        res.g = mix_channel(lo.g, hi.g, frac);
        res.b = mix_channel(lo.b, hi.b, frac);
        return res;
    endfunction

    // sample first so that a colour on the same edge finds its prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample.valid && sample.ready)
                expected_colours.push_back(predict_colour(sample.palette_sel,
                                                          sample.position));
            if (color.valid && color.ready)
            begin
                if (expected_colours.size() == 0)
                begin
                    $error("colour item with no sample waiting: red %0d green %0d blue %0d",
                           color.red, color.green, color.blue);
                    err_cnt++;
                end
                else
                begin
                    want = expected_colours.pop_front();
                    seen++;
                    if (color.red !== want.r)
                    begin
                        $error("red mismatch: expected %0d, actual %0d", want.r, color.red);
                        err_cnt++;
                    end
                    if (color.green !== want.g)
                    begin
                        $error("green mismatch: expected %0d, actual %0d",
                               want.g, color.green);
                        err_cnt++;
                    end
                    if (color.blue !== want.b)
                    begin
                        $error("blue mismatch: expected %0d, actual %0d", want.b, color.blue);
                        err_cnt++;
                    end
                end
            end
        end
        mismatches  <= err_cnt;
        outstanding <= expected_colours.size();
        checked     <= seen;
    end

endmodule

>>> test/palette_gradient_sampler_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_gradient_sampler_tb
// Drives palette and position items into the gradient sampler with random
// gaps on the sample side and random stalls on the colour side. A directed
// pass covers the ends of the position range, the key boundaries and the
// fallback palette, then random items follow in phases, some without any
// idling. The checker beside the block reports the mismatches.
// ----------------------------------------------------------------------------

module palette_gradient_sampler_tb;

    import pgs_pkg::*;

    localparam int FRAC_BITS = 16;
    localparam int ONE_POS   = 1 << FRAC_BITS;
    localparam int POS_MAX   = (1 << POS_W) - 1;
    localparam int MAX_WAIT  = 18;
    localparam int IDLE_LIMIT = 2000;
    // leave a margin after the last colour
    localparam int SETTLE_CYCLES = 10;
    localparam int RAND_PHASES = 13;
    localparam int PHASE_ITEMS = 100;

    // code outside the three palettes, read as ocean
    localparam logic [SEL_W-1:0] SEL_UNKNOWN = 2'd3;

    logic clk = 1'b0;
    logic rst_n;
    bit   no_idle = 1'b0;
    int   idle_cycles = 0;
    int   pal_items [0:3] = '{0, 0, 0, 0};
    int   clamp_items = 0;
    int   mismatches;
    int   outstanding;
    int   checked;

    pgs_sample_if sample_ch ();
    pgs_color_if  color_ch ();

    palette_gradient_sampler #(
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .color  (color_ch)
    );

    palette_gradient_sampler_checker #(
        .FRAC_BITS (FRAC_BITS)
    ) colour_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample_ch),
        .color       (color_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    always #1 clk = ~clk;

    // watchdog on cycles where no item moves on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((sample_ch.valid && sample_ch.ready) || (color_ch.valid && color_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // colour side: random stall before each item
    initial
    begin
        int stall;
        color_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                color_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            color_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!color_ch.valid);
        end
    end

    // one sample item after a random gap; valid stays high after acceptance
    task automatic issue_sample(input logic [SEL_W-1:0] sel, input int pos);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.palette_sel <= sel;
        sample_ch.position    <= pos[POS_W-1:0];
        do
            @(posedge clk);
        while (!sample_ch.ready);
        pal_items[sel]++;
        if (pos >= ONE_POS)
            clamp_items++;
    endtask

    // hold the sample side until every colour in flight has come out
    task automatic drain_colours();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // random position, weighted towards the useful range with some extremes
    function automatic int pick_position();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            case ($urandom_range(0, 4))
                0:       return 0;
                1:       return 1;
                2:       return ONE_POS - 1;
                3:       return ONE_POS;
                default: return POS_MAX;
            endcase
        end
        else if (pick == 1)
            return $urandom_range(ONE_POS + 1, POS_MAX);
        return $urandom_range(0, ONE_POS);
    endfunction

    initial
    begin
        int fails;
        sample_ch.valid       <= 1'b0;
        sample_ch.palette_sel <= SEL_OCEAN;
        sample_ch.position    <= '0;
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ends of the range on every palette code, fallback included
        for (int s = 0; s < 4; s++)
        begin
            issue_sample(s[SEL_W-1:0], 0);
            issue_sample(s[SEL_W-1:0], ONE_POS - 1);
            issue_sample(s[SEL_W-1:0], ONE_POS);
            issue_sample(s[SEL_W-1:0], POS_MAX);
        end
        // middle key of the three-key palettes
        issue_sample(SEL_OCEAN, ONE_POS / 2);
        issue_sample(SEL_SUNSET, ONE_POS / 2);
        issue_sample(SEL_UNKNOWN, ONE_POS / 2 + 1);
        // just past and just short of rainbow keys
        issue_sample(SEL_RAINBOW, 10923);
        issue_sample(SEL_RAINBOW, 21845);
        issue_sample(SEL_RAINBOW, 54613);
        issue_sample(SEL_RAINBOW, 1);
        issue_sample(SEL_SUNSET, 98304);

        drain_colours();

        // random phases, some without idling, some ending in a drain
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            no_idle = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
                issue_sample(SEL_W'($urandom_range(0, 3)), pick_position());
            if ($urandom_range(0, 2) == 0)
                drain_colours();
        end
        no_idle = 1'b0;

        // end of stimulus: wait for the last colours, then settle
        drain_colours();
        repeat (SETTLE_CYCLES) @(posedge clk);

        fails = mismatches;
        if (outstanding != 0)
        begin
            $error("%0d colour items never arrived", outstanding);
            fails++;
        end
        $display("samples: ocean %0d, sunset %0d, rainbow %0d, fallback code %0d",
                 pal_items[0], pal_items[1], pal_items[2], pal_items[3]);
        $display("%0d at or past 1.0; colours compared: %0d, mismatching fields: %0d",
                 clamp_items, checked, mismatches);
        if (fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
